### rtl/psb_pkg.sv
// psb_pkg: shared types and constants for the palette sprite blitter
// request/result payload structs, register index codes, frame and palette sizes
// no dependencies
package psb_pkg;

  // destination frame is MAX_DIM x MAX_DIM, coordinates DIM_W bits wide
  localparam int DIM_W    = 12;
  localparam int MAX_DIM  = 1 << DIM_W;
  localparam int CFG_W    = 13;

  // palette geometry
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int COLOUR_W  = 32;

  // apb geometry: eight 32-bit registers at 4-byte spacing
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // request kind
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // configuration register index
  typedef enum logic [2:0] {
    REG_POS_X       = 3'd0,
    REG_POS_Y       = 3'd1,
    REG_SRC_WIDTH   = 3'd2,
    REG_CLIP_LEFT   = 3'd3,
    REG_CLIP_RIGHT  = 3'd4,
    REG_CLIP_TOP    = 3'd5,
    REG_CLIP_BOTTOM = 3'd6,
    REG_KEY_ENABLE  = 3'd7
  } reg_idx_t;

  // one incoming request
  typedef struct packed {
    op_t                 opcode;
    logic [PAL_AW-1:0]   pixel_index;
    logic [COLOUR_W-1:0] load_colour;
    logic                last_pixel;
  } req_t;

  // one outgoing result
  typedef struct packed {
    logic                write_enable;
    logic [DIM_W-1:0]    dest_x;
    logic [DIM_W-1:0]    dest_y;
    logic [COLOUR_W-1:0] colour;
  } rsp_t;

endpackage

### rtl/palette_sprite_blit.sv
// palette_sprite_blit: indexed sprite blitter with clip window and colour key
// top level; register file, raster counters, palette memory, two-stage pipe
// depends on psb_pkg
// path: an accepted request passes through the first stage, then the result register
// throughput: one request per cycle while the pipe is not stalled; each request makes
// one palette access on the single-port palette memory, with a registered read
// stalls: the pipe keeps two requests in flight, so a request is still taken while a
// result waits if the first stage is empty; rst (synchronous) clears counters,
// registers and pipe valids; the palette is not cleared and reads as undefined until loaded
module palette_sprite_blit
  import psb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  // result channel
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  // apb register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic signed [CFG_W-1:0] pos_x;
  logic signed [CFG_W-1:0] pos_y;
  logic [CFG_W-1:0]        src_width;
  logic [CFG_W-1:0]        clip_left;
  logic [CFG_W-1:0]        clip_right;
  logic [CFG_W-1:0]        clip_top;
  logic [CFG_W-1:0]        clip_bottom;
  logic                    key_enable;

  reg_idx_t reg_sel;
  logic     reg_wr;

  // raster counters
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] column_count_next;
  logic [DIM_W-1:0] row_count_next;
  logic [DIM_W:0]   column_inc;
  logic             row_wrap;

  // front-end position and write decision
  logic signed [CFG_W+1:0] dx;
  logic signed [CFG_W+1:0] dy;
  logic                    x_ok;
  logic                    y_ok;
  logic                    we;

  // pipe control
  logic accept;
  logic advance;

  // first stage, beside the palette read register
  logic                s1_valid;
  logic                s1_we;
  logic [DIM_W-1:0]    s1_x;
  logic [DIM_W-1:0]    s1_y;
  logic [COLOUR_W-1:0] pal_rdata;

  // palette memory
  logic [COLOUR_W-1:0] palette [PAL_DEPTH];

  // apb decode
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      src_width   <= CFG_W'(1);
      clip_left   <= '0;
      clip_right  <= CFG_W'(MAX_DIM);
      clip_top    <= '0;
      clip_bottom <= CFG_W'(MAX_DIM);
      key_enable  <= 1'b0;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_POS_X:       pos_x       <= pwdata[CFG_W-1:0];
        REG_POS_Y:       pos_y       <= pwdata[CFG_W-1:0];
        REG_SRC_WIDTH:   src_width   <= pwdata[CFG_W-1:0];
        REG_CLIP_LEFT:   clip_left   <= pwdata[CFG_W-1:0];
        REG_CLIP_RIGHT:  clip_right  <= pwdata[CFG_W-1:0];
        REG_CLIP_TOP:    clip_top    <= pwdata[CFG_W-1:0];
        REG_CLIP_BOTTOM: clip_bottom <= pwdata[CFG_W-1:0];
        REG_KEY_ENABLE:  key_enable  <= pwdata[0];
        default:         ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (reg_sel)
      REG_POS_X:       prdata = APB_DW'(unsigned'(pos_x));
      REG_POS_Y:       prdata = APB_DW'(unsigned'(pos_y));
      REG_SRC_WIDTH:   prdata = APB_DW'(src_width);
      REG_CLIP_LEFT:   prdata = APB_DW'(clip_left);
      REG_CLIP_RIGHT:  prdata = APB_DW'(clip_right);
      REG_CLIP_TOP:    prdata = APB_DW'(clip_top);
      REG_CLIP_BOTTOM: prdata = APB_DW'(clip_bottom);
      REG_KEY_ENABLE:  prdata = APB_DW'(key_enable);
      default:         prdata = '0;
    endcase
  end

  // handshake: the first stage empties whenever the result register can move
  assign advance   = ~rsp_valid | ~rsp_stall;
  assign req_stall = s1_valid & ~advance;
  assign accept    = req_valid & ~req_stall;

  // destination position, signed with room for the largest clip bound
  assign dx = {{2{pos_x[CFG_W-1]}}, pos_x} + {{(CFG_W+2-DIM_W){1'b0}}, column_count};
  assign dy = {{2{pos_y[CFG_W-1]}}, pos_y} + {{(CFG_W+2-DIM_W){1'b0}}, row_count};

  // clip window and frame bounds
  assign x_ok = (dx >= $signed({2'b00, clip_left})) && (dx < $signed({2'b00, clip_right}))
                && (dx[CFG_W+1:DIM_W] == '0);
  assign y_ok = (dy >= $signed({2'b00, clip_top})) && (dy < $signed({2'b00, clip_bottom}))
                && (dy[CFG_W+1:DIM_W] == '0);
  assign we   = (req.opcode == OP_PIXEL) & x_ok & y_ok
                & ~(key_enable & (req.pixel_index == '0));

  // next raster position
  assign column_inc = {1'b0, column_count} + (DIM_W+1)'(1);
  assign row_wrap   = ({1'b0, column_inc} >= {1'b0, src_width}) | column_inc[DIM_W];

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (req.last_pixel) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_wrap) begin
      column_count_next = '0;
      row_count_next    = row_count + DIM_W'(1);
    end else begin
      column_count_next = column_inc[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && req.opcode == OP_PIXEL) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // palette: load writes a slot, a pixel reads one into the read register
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.opcode == OP_LOAD) begin
        palette[req.pixel_index] <= req.load_colour;
      end else begin
        pal_rdata <= palette[req.pixel_index];
      end
    end
  end

  // first stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_we <= we;
      s1_x  <= dx[DIM_W-1:0];
      s1_y  <= dy[DIM_W-1:0];
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  // result register payload, zero when nothing is written
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp.write_enable <= s1_we;
      rsp.dest_x       <= s1_we ? s1_x : '0;
      rsp.dest_y       <= s1_we ? s1_y : '0;
      rsp.colour       <= s1_we ? pal_rdata : '0;
    end
  end

endmodule

### rtl/psb_checker.sv
// psb_checker: port-level assertions for palette_sprite_blit
// bound to the top level at the end of this file
// depends on psb_pkg
module psb_checker
  import psb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // requests accepted but not yet delivered
  logic [1:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid & ~req_stall;
  assign rsp_acc = rsp_valid & ~rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // no result without a pending request, never more than two in flight
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid |-> pending != 2'd0) and (pending != 2'd3))
    else $error("result count does not match requests");

  // requests are only held off while a finished result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled with an empty result register");

  // a suppressed write carries zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.write_enable |->
      rsp.dest_x == '0 && rsp.dest_y == '0 && rsp.colour == '0)
    else $error("suppressed write with nonzero fields");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind palette_sprite_blit psb_checker u_psb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### tb/sv/tb_palette_sprite_blit.sv
// tb_palette_sprite_blit: self-checking bench for the palette sprite blitter
// directed stimulus table, partly with expected results in the table, and random
// sprite phases scored against an in-bench blit predictor; depends on psb_pkg and the block
module tb_palette_sprite_blit;
  import psb_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1900;

  typedef enum logic [1:0] {
    STEP_REG,
    STEP_REQ,
    STEP_REQ_KNOWN
  } step_kind_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // one row of the directed table
  typedef struct packed {
    step_kind_t  kind;
    reg_idx_t    ri;
    logic [12:0] val;
    req_t        r;
    rsp_t        want;
  } step_t;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // shadow of the block: palette, raster counters and registers
  logic [COLOUR_W-1:0] pal_shadow [PAL_DEPTH];
  bit                  pal_loaded [PAL_DEPTH];
  logic [7:0]          loaded_slots [$];
  int                  col_pos  = 0;
  int                  row_pos  = 0;
  int                  sprite_x = 0;
  int                  sprite_y = 0;
  int                  row_len  = 1;
  int                  clip_l   = 0;
  int                  clip_r   = 4096;
  int                  clip_t   = 0;
  int                  clip_b   = 4096;
  bit                  key_on   = 1'b0;

  rsp_t        pending_blits [$];
  int          mismatches   = 0;
  int          req_count    = 0;
  int          quiet_cycles = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b1;
  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;
  int          stall_tick   = 0;

  palette_sprite_blit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result of one request; updates the shadow state
  function automatic rsp_t blit_predict(req_t r);
    rsp_t o;
    int   dx;
    int   dy;
    bit   hit;
    o = '0;
    if (r.opcode == OP_LOAD) begin
      pal_shadow[r.pixel_index] = r.load_colour;
      if (!pal_loaded[r.pixel_index]) begin
        pal_loaded[r.pixel_index] = 1'b1;
        loaded_slots.push_back(r.pixel_index);
      end
      return o;
    end
    dx  = sprite_x + col_pos;
    dy  = sprite_y + row_pos;
    hit = dx >= clip_l && dx < clip_r && dy >= clip_t && dy < clip_b &&
          dx >= 0 && dx < MAX_DIM && dy >= 0 && dy < MAX_DIM;
    // colour key makes index zero transparent
    if (key_on && r.pixel_index == 8'd0) hit = 1'b0;
    if (hit) begin
      o.write_enable = 1'b1;
      o.dest_x       = dx[DIM_W-1:0];
      o.dest_y       = dy[DIM_W-1:0];
      o.colour       = pal_shadow[r.pixel_index];
    end
    // raster counters: last pixel clears, row wraps at width or frame edge
    if (r.last_pixel) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos + 1 >= row_len || col_pos + 1 >= MAX_DIM) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % MAX_DIM;
    end else begin
      col_pos = col_pos + 1;
    end
    return o;
  endfunction

  function automatic req_t make_req(op_t op, logic [7:0] idx, logic [31:0] c, logic last);
    req_t r;
    r.opcode      = op;
    r.pixel_index = idx;
    r.load_colour = c;
    r.last_pixel  = last;
    return r;
  endfunction

  function automatic step_t reg_step(reg_idx_t ri, int v);
    step_t s;
    s      = '0;
    s.kind = STEP_REG;
    s.ri   = ri;
    s.val  = v[12:0];
    return s;
  endfunction

  function automatic step_t req_row(step_kind_t k, op_t op, logic [7:0] idx,
                                    logic [31:0] c, logic last, logic we = 1'b0,
                                    int x = 0, int y = 0, logic [31:0] col = '0);
    step_t s;
    s                   = '0;
    s.kind              = k;
    s.r                 = make_req(op, idx, c, last);
    s.want.write_enable = we;
    s.want.dest_x       = x[DIM_W-1:0];
    s.want.dest_y       = y[DIM_W-1:0];
    s.want.colour       = col;
    return s;
  endfunction

  // only slots that hold a colour are ever drawn
  function automatic logic [7:0] pick_slot();
    if (key_on && $urandom_range(0, 3) == 0) return 8'd0;
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v)
      flag_error($sformatf("%s want %0h got %0h", name, want_v, got_v));
  endtask

  // apb write: setup then access, shadow updated at the write edge
  task automatic set_reg(reg_idx_t ri, int v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ri, 2'b00};
    pwdata  <= {19'b0, v[12:0]};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (ri)
      REG_POS_X:       sprite_x = $signed(v[12:0]);
      REG_POS_Y:       sprite_y = $signed(v[12:0]);
      REG_SRC_WIDTH:   row_len  = v[12:0];
      REG_CLIP_LEFT:   clip_l   = v[12:0];
      REG_CLIP_RIGHT:  clip_r   = v[12:0];
      REG_CLIP_TOP:    clip_t   = v[12:0];
      REG_CLIP_BOTTOM: clip_b   = v[12:0];
      REG_KEY_ENABLE:  key_on   = v[0];
      default:         ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off requests until every expected result has drained
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_blits.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  // send one request in bursts with random gaps, then queue its result
  task automatic push_req(req_t r, bit known = 1'b0, rsp_t want = '0);
    rsp_t predicted;
    int   gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        req_valid <= 1'b0;
        req       <= make_req(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              $urandom(), 1'($urandom_range(0, 1)));
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predicted = blit_predict(r);
    pending_blits.push_back(known ? want : predicted);
    req_count++;
  endtask

  task automatic send_pixel(logic last);
    push_req(make_req(OP_PIXEL, pick_slot(), $urandom(), last));
  endtask

  task automatic send_load();
    push_req(make_req(OP_LOAD, 8'($urandom_range(0, 255)), $urandom(),
                      1'($urandom_range(0, 1))));
  endtask

  // one random setting followed by a few sprites
  task automatic random_phase();
    int pick;
    int v;
    int w;
    int len;
    bit cut;
    bit open_end;
    settle();
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      set_reg(REG_CLIP_LEFT, $urandom_range(0, 20));
      set_reg(REG_CLIP_RIGHT, $urandom_range(0, 32));
      set_reg(REG_CLIP_TOP, $urandom_range(0, 20));
      set_reg(REG_CLIP_BOTTOM, $urandom_range(0, 32));
    end else if (pick < 9) begin
      set_reg(REG_CLIP_LEFT, 0);
      set_reg(REG_CLIP_RIGHT, MAX_DIM);
      set_reg(REG_CLIP_TOP, 0);
      set_reg(REG_CLIP_BOTTOM, MAX_DIM);
    end else begin
      set_reg(REG_CLIP_LEFT, $urandom_range(0, MAX_DIM));
      set_reg(REG_CLIP_RIGHT, $urandom_range(0, MAX_DIM));
      set_reg(REG_CLIP_TOP, $urandom_range(0, MAX_DIM));
      set_reg(REG_CLIP_BOTTOM, $urandom_range(0, MAX_DIM));
    end
    // sprite position: mostly near the window, sometimes at the frame extremes or anywhere in range
    for (int a = 0; a < 2; a++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) v = int'($urandom_range(0, 32)) - 8;
      else if (pick < 16) v = -4096 + int'($urandom_range(0, 8));
      else if (pick < 18) v = 4095 - int'($urandom_range(0, 8));
      else v = int'($urandom_range(0, 8191)) - 4096;
      if (a == 0) set_reg(REG_POS_X, v);
      else set_reg(REG_POS_Y, v);
    end
    pick = $urandom_range(0, 19);
    if (pick < 16) v = $urandom_range(1, 12);
    else if (pick == 16) v = 0;
    else if (pick == 17) v = MAX_DIM;
    else v = $urandom_range(13, MAX_DIM);
    set_reg(REG_SRC_WIDTH, v);
    set_reg(REG_KEY_ENABLE, $urandom_range(0, 1));
    gaps_on = ($urandom_range(0, 3) != 0);
    // sprites in raster order, with stray loads, early ends and open ends
    repeat ($urandom_range(1, 4)) begin
      w = (row_len == 0) ? 1 : row_len;
      if (w > 24) w = $urandom_range(1, 24);
      len      = w * $urandom_range(1, 6);
      open_end = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 8) send_load();
        cut = ($urandom_range(0, 99) < 3);
        send_pixel((k == len - 1 && !open_end) || cut);
        if (cut) break;
      end
    end
  endtask

  // receiver stall pattern, with a random mode: none, light, heavy or periodic
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
      default:     rsp_stall <= stall_tick[2];
    endcase
  end

  // result scoreboard
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_blits.size() == 0) begin
        flag_error($sformatf("result with nothing pending: we %0b x %0d y %0d colour %08h",
                             rsp.write_enable, rsp.dest_x, rsp.dest_y, rsp.colour));
      end else begin
        want = pending_blits.pop_front();
        check_field("write_enable", 32'(want.write_enable), 32'(rsp.write_enable));
        check_field("dest_x", 32'(want.dest_x), 32'(rsp.dest_x));
        check_field("dest_y", 32'(want.dest_y), 32'(rsp.dest_y));
        check_field("colour", want.colour, rsp.colour);
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL palette_sprite_blit");
      $finish;
    end
  end

  initial begin
    step_t script [$];
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // directed table: reset settings, key, frame extremes, empty and full clip
    script.push_back(req_row(STEP_REQ_KNOWN, OP_LOAD, 8'h00, 32'h1234_5678, 1'b0));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 1'b1));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_LOAD, 8'h55, 32'hA5A5_A5A5, 1'b0));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_LOAD, 8'hAA, 32'h5A5A_5A5A, 1'b0));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hFF, 32'h0, 1'b0,
                             1'b1, 0, 0, 32'hFFFF_FFFF));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'h00, 32'h0, 1'b0,
                             1'b1, 0, 1, 32'h1234_5678));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'h55, 32'h0, 1'b1,
                             1'b1, 0, 2, 32'hA5A5_A5A5));
    script.push_back(reg_step(REG_KEY_ENABLE, 1));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'h00, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hAA, 32'h0, 1'b1,
                             1'b1, 0, 1, 32'h5A5A_5A5A));
    script.push_back(reg_step(REG_POS_X, -4096));
    script.push_back(reg_step(REG_SRC_WIDTH, MAX_DIM));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hFF, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hFF, 32'h0, 1'b1));
    script.push_back(reg_step(REG_POS_X, 4095));
    script.push_back(reg_step(REG_POS_Y, 4095));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hFF, 32'h0, 1'b0,
                             1'b1, 4095, 4095, 32'hFFFF_FFFF));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'h55, 32'h0, 1'b1));
    script.push_back(reg_step(REG_CLIP_RIGHT, 0));
    script.push_back(reg_step(REG_CLIP_BOTTOM, 0));
    script.push_back(reg_step(REG_POS_X, 0));
    script.push_back(reg_step(REG_POS_Y, 0));
    script.push_back(reg_step(REG_KEY_ENABLE, 0));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hFF, 32'h0, 1'b1));
    script.push_back(reg_step(REG_CLIP_LEFT, MAX_DIM));
    script.push_back(reg_step(REG_CLIP_TOP, MAX_DIM));
    script.push_back(reg_step(REG_CLIP_RIGHT, MAX_DIM));
    script.push_back(reg_step(REG_CLIP_BOTTOM, MAX_DIM));
    script.push_back(req_row(STEP_REQ_KNOWN, OP_PIXEL, 8'hFF, 32'h0, 1'b1));
    // small window over a two-row sprite, scored by the predictor
    script.push_back(reg_step(REG_CLIP_LEFT, 2));
    script.push_back(reg_step(REG_CLIP_RIGHT, 4));
    script.push_back(reg_step(REG_CLIP_TOP, 1));
    script.push_back(reg_step(REG_CLIP_BOTTOM, 2));
    script.push_back(reg_step(REG_SRC_WIDTH, 5));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'hFF, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'h00, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'h55, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'hAA, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'hFF, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'h55, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'h00, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'hFF, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'hAA, 32'h0, 1'b0));
    script.push_back(req_row(STEP_REQ, OP_PIXEL, 8'h55, 32'h0, 1'b1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        settle();
        set_reg(script[i].ri, script[i].val);
      end else begin
        push_req(script[i].r, script[i].kind == STEP_REQ_KNOWN, script[i].want);
      end
    end

    while (req_count < RANDOM_ITEMS) random_phase();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_blits.size() == 0) begin
      $display("PASS palette_sprite_blit");
    end else begin
      $display("FAIL palette_sprite_blit");
    end
    $finish;
  end

endmodule

### sim.f
rtl/psb_pkg.sv
rtl/palette_sprite_blit.sv
rtl/psb_checker.sv
tb/sv/tb_palette_sprite_blit.sv
